### sv/ash_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ash_pkg
// Shared widths, reset values, register codes and stage types for the
// converter sample histogram.
// ----------------------------------------------------------------------------
package ash_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int LIMIT_W         = 11;
    localparam int COUNT_W         = 11;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = SAMPLE_W;

    localparam int BINS_DEF        = 256;
    localparam int MAX_CAPTURE_DEF = 1024;

    localparam logic [SAMPLE_W-1:0] BASE_RESET  = 12'd1950;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 11'd1000;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_VALUE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_LIMIT = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Work carried from the accept stage into the read-modify-write stage
    typedef struct packed {
        logic                wr;
        logic                rsp;
        logic                last;
        logic [SAMPLE_W-1:0] bar_value;
    } stage_ctrl_t;

    typedef struct packed {
        logic clearing;
        logic full;
    } front_status_t;

endpackage

### sv/ash_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ash_ram
// Simple dual-port RAM: one write port, one read port, registered read data
// that holds when no read is issued.
// ----------------------------------------------------------------------------
module ash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/ash_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ash_front
// Accept stage: configuration registers, capture bookkeeping, readout
// pointer, bin address and the clearing sweep over the count memory.
// ----------------------------------------------------------------------------
module ash_front import ash_pkg::*; #(
    parameter int BINS        = BINS_DEF,
    parameter int MAX_CAPTURE = MAX_CAPTURE_DEF,
    localparam int IDX_W      = $clog2(BINS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   op,
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic                   s1_hold,
    input  logic                   s1_valid,
    output logic                   in_stall,
    output logic                   issue_valid,
    output stage_ctrl_t            issue_ctrl,
    output logic [IDX_W-1:0]       issue_addr,
    output logic                   clr_we,
    output logic [IDX_W-1:0]       clr_addr,
    output front_status_t          status
);

    localparam int CNT_W  = $clog2(MAX_CAPTURE + 1);
    localparam int WIDE_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [WIDE_W-1:0]   MAX_LIM     = WIDE_W'(MAX_CAPTURE);
    localparam logic [SAMPLE_W:0]   BINS_X      = (SAMPLE_W + 1)'(BINS);
    localparam logic [SAMPLE_W:0]   LAST_IDX_X  = (SAMPLE_W + 1)'(BINS - 1);
    localparam logic [IDX_W-1:0]    LAST_IDX    = IDX_W'(BINS - 1);

    logic [SAMPLE_W-1:0] base_value_reg, base_value_next;
    logic [LIMIT_W-1:0]  capture_limit_reg, capture_limit_next;
    logic [CNT_W-1:0]    captured_reg, captured_next;
    logic [SAMPLE_W-1:0] largest_reg, largest_next;
    logic                any_reg, any_next;
    logic [IDX_W-1:0]    rptr_reg, rptr_next;
    logic                clearing_reg, clearing_next;
    logic [IDX_W-1:0]    clr_addr_reg, clr_addr_next;

    logic [WIDE_W-1:0]   lim_raw;
    logic [WIDE_W-1:0]   eff_lim;
    logic                full;
    logic                accept;
    logic                in_window;
    logic [SAMPLE_W-1:0] offset;
    logic                in_bins;
    logic [SAMPLE_W-1:0] top_diff;
    logic                top_valid;
    logic [IDX_W-1:0]    end_idx;
    logic                is_last;

    always_comb
    begin
        lim_raw = WIDE_W'(capture_limit_reg);
        if (lim_raw == '0)
        begin
            eff_lim = WIDE_W'(1);
        end
        else if (lim_raw > MAX_LIM)
        begin
            eff_lim = MAX_LIM;
        end
        else
        begin
            eff_lim = lim_raw;
        end
    end

    assign full      = WIDE_W'(captured_reg) >= eff_lim;
    assign in_stall  = clearing_reg || s1_hold;
    assign accept    = in_valid && !in_stall;
    assign in_window = sample >= base_value_reg;
    assign offset    = sample - base_value_reg;
    assign in_bins   = {1'b0, offset} < BINS_X;
    assign top_diff  = largest_reg - base_value_reg;
    assign top_valid = any_reg && (largest_reg >= base_value_reg);

    // Final bar: largest capture clamped to the last bin, or the first bin
    always_comb
    begin
        if (!top_valid)
        begin
            end_idx = '0;
        end
        else if ({1'b0, top_diff} > LAST_IDX_X)
        begin
            end_idx = LAST_IDX;
        end
        else
        begin
            end_idx = top_diff[IDX_W-1:0];
        end
    end

    assign is_last = rptr_reg >= end_idx;

    always_comb
    begin
        base_value_next    = base_value_reg;
        capture_limit_next = capture_limit_reg;
        captured_next      = captured_reg;
        largest_next       = largest_reg;
        any_next           = any_reg;
        rptr_next          = rptr_reg;
        clearing_next      = clearing_reg;
        clr_addr_next      = clr_addr_reg;
        issue_ctrl         = '0;
        issue_addr         = offset[IDX_W-1:0];

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BASE_VALUE:    base_value_next    = cfg_data;
                CFG_CAPTURE_LIMIT: capture_limit_next = cfg_data[LIMIT_W-1:0];
                default:           ;
            endcase
        end

        if (accept)
        begin
            case (op)
                OP_SAMPLE:
                begin
                    if (!full)
                    begin
                        captured_next = captured_reg + CNT_W'(1);
                        if (sample > largest_reg)
                        begin
                            largest_next = sample;
                        end
                        if (in_window)
                        begin
                            any_next = 1'b1;
                            issue_ctrl.wr = in_bins;
                        end
                    end
                end
                OP_READ:
                begin
                    if (full)
                    begin
                        issue_ctrl.rsp       = 1'b1;
                        issue_ctrl.last      = is_last;
                        issue_ctrl.bar_value = base_value_reg + SAMPLE_W'(rptr_reg);
                        issue_addr           = rptr_reg;
                        if (is_last)
                        begin
                            // drop the capture and sweep the counts back to zero
                            captured_next = '0;
                            largest_next  = '0;
                            any_next      = 1'b0;
                            rptr_next     = '0;
                            clearing_next = 1'b1;
                            clr_addr_next = '0;
                        end
                        else
                        begin
                            rptr_next = rptr_reg + IDX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end

        if (clr_we)
        begin
            if (clr_addr_reg == LAST_IDX)
            begin
                clearing_next = 1'b0;
                clr_addr_next = '0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + IDX_W'(1);
            end
        end
    end

    // Hold the sweep until the last bar has left the modify stage
    assign clr_we      = clearing_reg && !s1_valid;
    assign clr_addr    = clr_addr_reg;
    assign issue_valid = accept && (issue_ctrl.wr || issue_ctrl.rsp);

    assign status.clearing = clearing_reg;
    assign status.full     = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_value_reg    <= BASE_RESET;
            capture_limit_reg <= LIMIT_RESET;
            captured_reg      <= '0;
            largest_reg       <= '0;
            any_reg           <= 1'b0;
            rptr_reg          <= '0;
            clearing_reg      <= 1'b1;
            clr_addr_reg      <= '0;
        end
        else
        begin
            base_value_reg    <= base_value_next;
            capture_limit_reg <= capture_limit_next;
            captured_reg      <= captured_next;
            largest_reg       <= largest_next;
            any_reg           <= any_next;
            rptr_reg          <= rptr_next;
            clearing_reg      <= clearing_next;
            clr_addr_reg      <= clr_addr_next;
        end
    end

endmodule

### sv/ash_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ash_update
// Modify stage: increments a bin count read from memory, forwarding the most
// recent write, and loads bars into the output register.
// ----------------------------------------------------------------------------
module ash_update import ash_pkg::*; #(
    parameter int BINS        = BINS_DEF,
    parameter int MAX_CAPTURE = MAX_CAPTURE_DEF,
    localparam int IDX_W      = $clog2(BINS),
    localparam int CNT_W      = $clog2(MAX_CAPTURE + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue_valid,
    input  stage_ctrl_t         issue_ctrl,
    input  logic [IDX_W-1:0]    issue_addr,
    input  logic [CNT_W-1:0]    rd_data,
    input  logic                clr_we,
    input  logic [IDX_W-1:0]    clr_addr,
    input  logic                out_stall,
    output logic                s1_hold,
    output logic                s1_valid,
    output logic                s1_bin_write,
    output logic                s1_final,
    output logic                ram_we,
    output logic [IDX_W-1:0]    ram_addr,
    output logic [CNT_W-1:0]    ram_wdata,
    output logic                out_valid,
    output logic [SAMPLE_W-1:0] bar_value,
    output logic [COUNT_W-1:0]  bar_count,
    output logic                last_bar
);

    localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic                s1_valid_reg, s1_valid_next;
    stage_ctrl_t         s1_ctrl_reg, s1_ctrl_next;
    logic [IDX_W-1:0]    s1_addr_reg, s1_addr_next;
    logic                fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]    fwd_addr_reg, fwd_addr_next;
    logic [CNT_W-1:0]    fwd_data_reg, fwd_data_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] bar_value_reg, bar_value_next;
    logic [COUNT_W-1:0]  bar_count_reg, bar_count_next;
    logic                last_bar_reg, last_bar_next;

    logic [CNT_W-1:0]    cur_count;
    logic [EXT_W-1:0]    cur_ext;
    logic                out_load;

    // Write landing on the same edge as our read is not in rd_data yet
    assign cur_count = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                         : rd_data;
    assign cur_ext   = EXT_W'(cur_count);

    assign s1_hold      = s1_valid_reg && s1_ctrl_reg.rsp && out_valid_reg && out_stall;
    assign s1_valid     = s1_valid_reg;
    assign s1_bin_write = s1_valid_reg && s1_ctrl_reg.wr;
    assign out_load     = s1_valid_reg && s1_ctrl_reg.rsp && !s1_hold;
    assign s1_final     = out_load && s1_ctrl_reg.last;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = clr_addr;
        ram_wdata = '0;
        if (s1_bin_write)
        begin
            ram_we    = 1'b1;
            ram_addr  = s1_addr_reg;
            ram_wdata = cur_count + CNT_W'(1);
        end
        else if (clr_we)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_ctrl_next   = s1_ctrl_reg;
        s1_addr_next   = s1_addr_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_addr_next  = fwd_addr_reg;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_valid_reg;
        bar_value_next = bar_value_reg;
        bar_count_next = bar_count_reg;
        last_bar_next  = last_bar_reg;

        if (!s1_hold)
        begin
            s1_valid_next = issue_valid;
            if (issue_valid)
            begin
                s1_ctrl_next = issue_ctrl;
                s1_addr_next = issue_addr;
            end
        end

        if (ram_we)
        begin
            fwd_valid_next = 1'b1;
            fwd_addr_next  = ram_addr;
            fwd_data_next  = ram_wdata;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            bar_value_next = s1_ctrl_reg.bar_value;
            bar_count_next = cur_ext[COUNT_W-1:0];
            last_bar_next  = s1_ctrl_reg.last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctrl_reg   <= s1_ctrl_next;
        s1_addr_reg   <= s1_addr_next;
        fwd_addr_reg  <= fwd_addr_next;
        fwd_data_reg  <= fwd_data_next;
        bar_value_reg <= bar_value_next;
        bar_count_reg <= bar_count_next;
        last_bar_reg  <= last_bar_next;
    end

    assign out_valid = out_valid_reg;
    assign bar_value = bar_value_reg;
    assign bar_count = bar_count_reg;
    assign last_bar  = last_bar_reg;

endmodule

### sv/adc_sample_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_sample_histogram_core
// Histogram of converter samples: bin counts live in one RAM, updated by a
// read-modify-write stage; read requests return one bar per transfer.
// Throughput: one item per cycle while in_stall is low; samples hitting the same bin
// back to back are served by forwarding the last RAM write.
// Read path: a bar's count is read from the RAM on the accept edge into the modify
// stage, then loaded into the output register; samples produce no transfer.
// Reset: counts are swept to zero after reset and again after each final bar, once
// the final bar has left the modify stage (later while out_stall holds it there);
// input is stalled during the sweep.
// ----------------------------------------------------------------------------
module adc_sample_histogram_core import ash_pkg::*; #(
    parameter int BINS        = BINS_DEF,
    parameter int MAX_CAPTURE = MAX_CAPTURE_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [SAMPLE_W-1:0]    sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_W-1:0]    bar_value,
    output logic [COUNT_W-1:0]     bar_count,
    output logic                   last_bar
);

    localparam int IDX_W = $clog2(BINS);
    localparam int CNT_W = $clog2(MAX_CAPTURE + 1);

    logic             s1_hold;
    logic             s1_valid;
    logic             s1_bin_write;
    logic             s1_final;
    logic             issue_valid;
    stage_ctrl_t      issue_ctrl;
    logic [IDX_W-1:0] issue_addr;
    logic             clr_we;
    logic [IDX_W-1:0] clr_addr;
    front_status_t    status;
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [CNT_W-1:0] ram_wdata;
    logic [CNT_W-1:0] rd_data;

    // The user must write registers only while idle; the block does not enforce it
    assign cfg_ready = 1'b1;

    ash_front #(
        .BINS        (BINS),
        .MAX_CAPTURE (MAX_CAPTURE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .op          (op),
        .sample      (sample),
        .s1_hold     (s1_hold),
        .s1_valid    (s1_valid),
        .in_stall    (in_stall),
        .issue_valid (issue_valid),
        .issue_ctrl  (issue_ctrl),
        .issue_addr  (issue_addr),
        .clr_we      (clr_we),
        .clr_addr    (clr_addr),
        .status      (status)
    );

    ash_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BINS)
    ) u_bin_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_addr),
        .wr_data (ram_wdata),
        .rd_en   (issue_valid),
        .rd_addr (issue_addr),
        .rd_data (rd_data)
    );

    ash_update #(
        .BINS        (BINS),
        .MAX_CAPTURE (MAX_CAPTURE)
    ) u_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue_valid  (issue_valid),
        .issue_ctrl   (issue_ctrl),
        .issue_addr   (issue_addr),
        .rd_data      (rd_data),
        .clr_we       (clr_we),
        .clr_addr     (clr_addr),
        .out_stall    (out_stall),
        .s1_hold      (s1_hold),
        .s1_valid     (s1_valid),
        .s1_bin_write (s1_bin_write),
        .s1_final     (s1_final),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .out_valid    (out_valid),
        .bar_value    (bar_value),
        .bar_count    (bar_count),
        .last_bar     (last_bar)
    );

    // The final bar always leaves with the clearing sweep pending
    a_final_bar_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_final |-> status.clearing)
        else $error("final bar left without a clearing sweep");

    // No bin increment may overlap the clearing sweep
    a_no_count_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !s1_bin_write)
        else $error("bin write during clearing sweep");

    // A bar request issued to the RAM reaches the modify stage next cycle
    a_request_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (issue_valid && issue_ctrl.rsp) |=> s1_valid)
        else $error("bar request lost between issue and modify stage");

endmodule

### sim/tb_adc_sample_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_sample_histogram_core
// Self-checking bench for the converter sample histogram. A behavioral
// predictor keeps its own bins and capture state, computes every bar at the
// moment its request is accepted, and compares it field by field with the
// bars the core hands out. Directed captures cover window edges, empty
// windows, base moves mid-capture and mid-readout, a full-size capture and
// output back-pressure; random captures with bursty input and a stalling
// receiver follow.
// ----------------------------------------------------------------------------
module tb_adc_sample_histogram_core;
    import ash_pkg::*;

    localparam int HIST_BINS     = BINS_DEF;
    localparam int CAPTURE_MAX   = MAX_CAPTURE_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 350;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } bar_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   op;
    logic [SAMPLE_W-1:0]    sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [SAMPLE_W-1:0]    bar_value;
    logic [COUNT_W-1:0]     bar_count;
    logic                   last_bar;

    // predictor state
    int unsigned         hist_bins [HIST_BINS];
    int unsigned         cap_count;
    int unsigned         bar_ptr;
    int unsigned         max_sample;
    bit                  seen_in_window;
    bit                  readout_over;
    logic [SAMPLE_W-1:0] cur_base;
    logic [LIMIT_W-1:0]  cur_limit;
    bar_t                expected_bars [$];

    int error_count     = 0;
    int effective_items = 0;
    int burst_left      = 0;
    int gap_limit       = 0;
    int hold_request    = 0;

    adc_sample_histogram_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bar_value (bar_value),
        .bar_count (bar_count),
        .last_bar  (last_bar)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(64'd20_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned active_limit();
        int unsigned lim;
        lim = cur_limit;
        if (lim < 1)
            lim = 1;
        if (lim > CAPTURE_MAX)
            lim = CAPTURE_MAX;
        return lim;
    endfunction

    function automatic bit capture_full();
        return cap_count >= active_limit();
    endfunction

    task automatic clear_histogram();
        foreach (hist_bins[i])
            hist_bins[i] = 0;
        cap_count      = 0;
        bar_ptr        = 0;
        max_sample     = 0;
        seen_in_window = 1'b0;
    endtask

    // Apply one accepted item to the predictor; queue the bar it yields.
    task automatic predict_item(input logic item_op, input logic [SAMPLE_W-1:0] smp,
                                output bit took_effect);
        int unsigned offset;
        int unsigned bar_end;
        int unsigned ptr;
        bar_t        bar;
        took_effect = 1'b0;
        if (item_op == OP_SAMPLE)
        begin
            if (!capture_full())
            begin
                took_effect = 1'b1;
                cap_count++;
                if (smp > max_sample)
                    max_sample = smp;
                if (smp >= cur_base)
                begin
                    offset         = smp - cur_base;
                    seen_in_window = 1'b1;
                    if (offset < HIST_BINS)
                        hist_bins[offset]++;
                end
            end
        end
        else if (capture_full())
        begin
            took_effect = 1'b1;
            bar_end     = 0;
            ptr         = bar_ptr;
            if (seen_in_window && max_sample >= cur_base)
            begin
                bar_end = max_sample - cur_base;
                if (bar_end > HIST_BINS - 1)
                    bar_end = HIST_BINS - 1;
            end
            if (ptr > HIST_BINS - 1)
                ptr = HIST_BINS - 1;
            bar.value = SAMPLE_W'(cur_base + ptr);
            bar.count = COUNT_W'(hist_bins[ptr]);
            bar.last  = (ptr >= bar_end);
            expected_bars.push_back(bar);
            if (bar.last)
            begin
                clear_histogram();
                readout_over = 1'b1;
            end
            else
                bar_ptr = ptr + 1;
        end
    endtask

    // Offer one item in bursts with random gaps; return once it is transferred.
    task automatic send_item(input logic item_op, input logic [SAMPLE_W-1:0] item_sample);
        int gap;
        bit took;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_limit == 0 || $urandom_range(0, 1) == 0) ? 0
                                                                : $urandom_range(1, gap_limit);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        op       <= item_op;
        sample   <= item_sample;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(item_op, item_sample, took);
        if (took)
            effective_items++;
    endtask

    // Hold input until every expected bar has arrived and the pipe settles.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_cfg(input bit set_base, input logic [SAMPLE_W-1:0] base_data,
                             input bit set_limit, input logic [CFG_DATA_W-1:0] limit_data);
        if (set_base)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_BASE_VALUE;
            cfg_data  <= base_data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cur_base = base_data;
        end
        if (set_limit)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_CAPTURE_LIMIT;
            cfg_data  <= limit_data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cur_limit = limit_data[LIMIT_W-1:0];
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_out_all();
        readout_over = 1'b0;
        while (!readout_over)
            send_item(OP_READ, SAMPLE_W'($urandom));
    endtask

    // Bins at and around the window base, a sample below it, a request
    // before the capture is full and a sample after it is full.
    task automatic test_window_edges();
        gap_limit = 3;
        wait_drained();
        write_cfg(1'b1, 12'd1000, 1'b1, 12'd5);
        send_item(OP_READ, 12'hFFF);
        send_item(OP_SAMPLE, 12'd999);
        send_item(OP_SAMPLE, 12'd1000);
        send_item(OP_SAMPLE, 12'd1000);
        send_item(OP_SAMPLE, 12'd1003);
        send_item(OP_SAMPLE, 12'd0);
        send_item(OP_SAMPLE, 12'hFFF);
        read_out_all();
    endtask

    // Nothing at or above base gives one empty bar; limit 0 acts as 1.
    task automatic test_empty_window();
        wait_drained();
        write_cfg(1'b1, 12'hFFF, 1'b1, 12'h800);
        send_item(OP_SAMPLE, 12'hFFE);
        read_out_all();
        wait_drained();
        write_cfg(1'b0, '0, 1'b1, 12'd2);
        send_item(OP_SAMPLE, 12'hFFF);
        send_item(OP_SAMPLE, 12'hFFF);
        read_out_all();
    endtask

    // Move the base mid-capture, then mid-readout past the read pointer.
    task automatic test_base_change();
        wait_drained();
        write_cfg(1'b1, 12'd0, 1'b1, 12'd4);
        send_item(OP_SAMPLE, 12'd0);
        send_item(OP_SAMPLE, 12'd2);
        wait_drained();
        write_cfg(1'b1, 12'd1, 1'b0, '0);
        send_item(OP_SAMPLE, 12'd3);
        send_item(OP_SAMPLE, 12'd5);
        send_item(OP_READ, 12'd0);
        send_item(OP_READ, 12'd0);
        wait_drained();
        write_cfg(1'b1, 12'd4, 1'b0, '0);
        read_out_all();
    endtask

    // Largest capture, all in one bin, back to back; limit above max clamps.
    task automatic test_full_capture();
        gap_limit = 0;
        wait_drained();
        write_cfg(1'b1, 12'd3000, 1'b1, 12'hFFF);
        repeat (CAPTURE_MAX)
            send_item(OP_SAMPLE, 12'd3000);
        send_item(OP_SAMPLE, 12'd3000);
        read_out_all();
    endtask

    // Receiver holds off while requests keep coming, then the sender drains.
    task automatic test_backpressure();
        gap_limit = 0;
        wait_drained();
        write_cfg(1'b1, 12'd200, 1'b1, 12'd40);
        send_item(OP_SAMPLE, 12'd260);
        repeat (39)
            send_item(OP_SAMPLE, 12'(200 + $urandom_range(0, 60)));
        hold_request = 300;
        repeat (30)
            send_item(OP_READ, SAMPLE_W'($urandom));
        wait_drained();
        read_out_all();
    endtask

    task automatic test_random_captures();
        int                  target;
        int                  span;
        int                  pick;
        int                  limit_val;
        logic [SAMPLE_W-1:0] new_base;
        target = effective_items + RANDOM_ITEMS;
        while (effective_items < target)
        begin
            wait_drained();
            gap_limit = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 4))
                    0:       new_base = '0;
                    1:       new_base = '1;
                    2:       new_base = SAMPLE_W'($urandom_range(3840, 4095));
                    default: new_base = SAMPLE_W'($urandom);
                endcase
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    limit_val = $urandom_range(1, 24);
                else if (pick < 17)
                    limit_val = $urandom_range(25, 96);
                else if (pick < 19)
                    limit_val = $urandom_range(97, 300);
                else
                    limit_val = 0;
                write_cfg(1'b1, new_base, 1'b1,
                          {1'($urandom_range(0, 1)), LIMIT_W'(limit_val)});
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: span = $urandom_range(0, 7);
                5, 6, 7:       span = $urandom_range(8, 40);
                default:       span = $urandom_range(41, 300);
            endcase
            readout_over = 1'b0;
            while (!readout_over)
            begin
                pick = $urandom_range(0, 199);
                if (pick < 2)
                begin
                    // nudge the base while the capture or readout is under way
                    wait_drained();
                    write_cfg(1'b1, SAMPLE_W'(cur_base + $urandom_range(0, 8) - 4),
                              1'b0, '0);
                end
                else if (capture_full())
                begin
                    if (pick < 10)
                        send_item(OP_SAMPLE, SAMPLE_W'($urandom));
                    else
                        send_item(OP_READ, SAMPLE_W'($urandom));
                end
                else if (pick < 12)
                    send_item(OP_READ, SAMPLE_W'($urandom));
                else if (pick < 150)
                    send_item(OP_SAMPLE, SAMPLE_W'(cur_base + $urandom_range(0, span)));
                else if (pick < 185 && cur_base != 0)
                    send_item(OP_SAMPLE, SAMPLE_W'($urandom_range(0, cur_base - 1)));
                else
                    send_item(OP_SAMPLE, SAMPLE_W'($urandom));
            end
        end
    endtask

    // Receiver: stall on changing patterns, or hold off on request.
    initial
    begin : receiver
        int hold_left;
        int mode_left;
        int stall_mode;
        hold_left  = 0;
        mode_left  = 0;
        stall_mode = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(50, 400);
                end
                mode_left--;
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ($urandom_range(0, 7) == 0) ? !out_stall : out_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : bar_check
        bar_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bars.size() == 0)
                report_mismatch($sformatf("unexpected bar value %0d count %0d last %0d",
                                          bar_value, bar_count, last_bar));
            else
            begin
                want = expected_bars.pop_front();
                if (bar_value !== want.value)
                    report_mismatch($sformatf("bar_value got %0d want %0d",
                                              bar_value, want.value));
                if (bar_count !== want.count)
                    report_mismatch($sformatf("bar_count at %0d got %0d want %0d",
                                              want.value, bar_count, want.count));
                if (last_bar !== want.last)
                    report_mismatch($sformatf("last_bar at %0d got %0d want %0d",
                                              want.value, last_bar, want.last));
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        op        <= OP_SAMPLE;
        sample    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BASE_VALUE;
        cfg_data  <= '0;
        cur_base  = BASE_RESET;
        cur_limit = LIMIT_RESET;
        readout_over = 1'b0;
        clear_histogram();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_window_edges();
        test_empty_window();
        test_base_change();
        test_full_capture();
        test_backpressure();
        test_random_captures();

        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
